### hdl/hbd_pkg.sv
// Shared types and constants of the prefix-code bitstream decoder.
// Used by hbd_front, hbd_back and the top level; depends on nothing.
package hbd_pkg;

    localparam int DEF_TABLE_DEPTH  = 256;
    localparam int DEF_MAX_CODE_LEN = 32;
    localparam int BYTE_BITS        = 8;
    localparam int TOP_BIT          = 7;
    localparam int IN_QUEUE_DEPTH   = 2;
    localparam int OUT_QUEUE_DEPTH  = 4;
    localparam int RESULT_BITS      = 10;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_START  = 2'd2,
        CMD_DECODE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SEARCH,
        ST_EMIT,
        ST_FLUSH
    } t_state;

    // One classified input word as it waits for the engine
    typedef struct packed {
        t_cmd        cmd;
        logic        len_ok;
        logic [5:0]  len;
        logic [31:0] bits;
        logic [7:0]  sym;
        logic [7:0]  data;
        logic [3:0]  nbits;
    } t_item;

endpackage

### hdl/hbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module hbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/hbd_fifo.sv
// Small register queue used on the input and result sides.
// Standalone; no package needed.
module hbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store the word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

### hdl/hbd_front.sv
// Front end: classifies each input word and queues it for the engine.
// Depends on hbd_pkg and hbd_fifo.
module hbd_front #(
    parameter int MAX_CODE_LEN = hbd_pkg::DEF_MAX_CODE_LEN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_command,
    input  logic [5:0]    i_code_length,
    input  logic [31:0]   i_code_bits,
    input  logic [7:0]    i_symbol_in,
    input  logic [7:0]    i_data_byte,
    input  logic [3:0]    i_valid_bits,
    input  logic          i_pop,
    output logic          o_avail,
    output hbd_pkg::t_item o_item
);
    hbd_pkg::t_item item;
    logic           q_empty;
    logic [$bits(hbd_pkg::t_item)-1:0] q_out;

    // Classify: length check and bit count clamp
    always_comb begin
        item.cmd    = hbd_pkg::t_cmd'(i_command);
        item.len_ok = (i_code_length != 6'd0) && (32'(i_code_length) <= MAX_CODE_LEN);
        item.len    = i_code_length;
        item.bits   = i_code_bits;
        item.sym    = i_symbol_in;
        item.data   = i_data_byte;
        item.nbits  = (i_valid_bits > 4'(hbd_pkg::BYTE_BITS)) ?
                      4'(hbd_pkg::BYTE_BITS) : i_valid_bits;
    end

    hbd_fifo #(
        .WIDTH ($bits(hbd_pkg::t_item)),
        .DEPTH (hbd_pkg::IN_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (item),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    assign o_avail = !q_empty;
    assign o_item  = hbd_pkg::t_item'(q_out);
endmodule

### hdl/hbd_back.sv
// Back end: table loading and the bit-serial decode engine with table search.
// Depends on hbd_pkg and hbd_ram.
module hbd_back #(
    parameter int TABLE_DEPTH  = hbd_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_CODE_LEN = hbd_pkg::DEF_MAX_CODE_LEN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_avail,
    input  hbd_pkg::t_item                 i_item,
    output logic                           o_pop,
    input  logic                           i_out_full,
    output logic                           o_out_push,
    output logic [hbd_pkg::RESULT_BITS-1:0] o_out_data
);
    localparam int W  = MAX_CODE_LEN;
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int HW = $clog2(MAX_CODE_LEN + 2);
    localparam int IW = $clog2(MAX_CODE_LEN);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = LW + W + 8;

    hbd_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [LW-1:0]   r_longest, n_longest;
    logic [W-1:0]    r_present, n_present;
    logic [W-1:0]    r_buf, n_buf;
    logic [HW-1:0]   r_held, n_held;
    logic [7:0]      r_data, n_data;
    logic [3:0]      r_left, n_left;
    logic [CW-1:0]   r_addr, n_addr;
    logic            r_cmp_v, n_cmp_v;
    logic [7:0]      r_new_sym, n_new_sym;
    logic            r_new_err, n_new_err;
    logic            r_pend_v, n_pend_v;
    logic [7:0]      r_pend_sym, n_pend_sym;
    logic            r_pend_err, n_pend_err;

    logic            ram_we, ram_re;
    logic [EW-1:0]   ram_wdata, ram_rdata;
    logic [LW-1:0]   e_len;
    logic [W-1:0]    e_bits;
    logic [7:0]      e_sym;
    logic [W-1:0]    load_bits, held_mask, buf_sh;
    logic [HW-1:0]   held_sh;
    logic            hit, may_match;

    hbd_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Entry compare against the buffered code
    assign {e_len, e_bits, e_sym} = ram_rdata;
    assign load_bits = W'(i_item.bits) & ~({W{1'b1}} << i_item.len);
    assign ram_wdata = {LW'(i_item.len), load_bits, i_item.sym};
    assign held_mask = ~({W{1'b1}} << r_held);
    assign hit       = r_cmp_v && (HW'(e_len) == r_held) && (e_bits == (r_buf & held_mask));
    assign buf_sh    = {r_buf[W-2:0], r_data[hbd_pkg::TOP_BIT]};
    assign held_sh   = r_held + 1'b1;
    assign may_match = (held_sh <= HW'(MAX_CODE_LEN)) &&
                       r_present[IW'(held_sh - 1'b1)];

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= hbd_pkg::ST_IDLE;
            r_count   <= '0;
            r_longest <= '0;
            r_present <= '0;
            r_buf     <= '0;
            r_held    <= '0;
            r_pend_v  <= 1'b0;
            r_cmp_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_longest <= n_longest;
            r_present <= n_present;
            r_buf     <= n_buf;
            r_held    <= n_held;
            r_pend_v  <= n_pend_v;
            r_cmp_v   <= n_cmp_v;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_left     <= n_left;
        r_addr     <= n_addr;
        r_new_sym  <= n_new_sym;
        r_new_err  <= n_new_err;
        r_pend_sym <= n_pend_sym;
        r_pend_err <= n_pend_err;
    end

    // Next state and outputs
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_longest  = r_longest;
        n_present  = r_present;
        n_buf      = r_buf;
        n_held     = r_held;
        n_data     = r_data;
        n_left     = r_left;
        n_addr     = r_addr;
        n_cmp_v    = r_cmp_v;
        n_new_sym  = r_new_sym;
        n_new_err  = r_new_err;
        n_pend_v   = r_pend_v;
        n_pend_sym = r_pend_sym;
        n_pend_err = r_pend_err;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        o_pop      = 1'b0;
        o_out_push = 1'b0;
        o_out_data = {r_pend_sym, r_pend_err, 1'b0};
        unique case (r_state)
            hbd_pkg::ST_IDLE: begin
                if (i_avail) begin
                    o_pop = 1'b1;
                    unique case (i_item.cmd)
                        hbd_pkg::CMD_CLEAR: begin
                            n_count   = '0;
                            n_longest = '0;
                            n_present = '0;
                        end
                        hbd_pkg::CMD_LOAD: begin
                            if (i_item.len_ok && (r_count < CW'(TABLE_DEPTH))) begin
                                ram_we  = 1'b1;
                                n_count = r_count + 1'b1;
                                n_present[IW'(i_item.len - 6'd1)] = 1'b1;
                                if (LW'(i_item.len) > r_longest) begin
                                    n_longest = LW'(i_item.len);
                                end
                            end
                        end
                        hbd_pkg::CMD_START: begin
                            n_buf  = '0;
                            n_held = '0;
                        end
                        hbd_pkg::CMD_DECODE: begin
                            n_data   = i_item.data;
                            n_left   = i_item.nbits;
                            n_pend_v = 1'b0;
                            if (i_item.nbits != 4'd0) begin
                                n_state = hbd_pkg::ST_SHIFT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            hbd_pkg::ST_SHIFT: begin
                // Take one bit, then decide whether to search the table, report an error or finish the byte
                n_data = {r_data[6:0], 1'b0};
                n_left = r_left - 1'b1;
                n_buf  = buf_sh;
                n_held = held_sh;
                if (may_match) begin
                    n_addr  = '0;
                    n_cmp_v = 1'b0;
                    n_state = hbd_pkg::ST_SEARCH;
                end else if (held_sh > HW'(r_longest)) begin
                    n_new_sym = '0;
                    n_new_err = 1'b1;
                    n_state   = hbd_pkg::ST_EMIT;
                end else if (r_left == 4'd1) begin
                    n_state = hbd_pkg::ST_FLUSH;
                end
            end
            hbd_pkg::ST_SEARCH: begin
                // Walk the loaded entries; first hit wins
                if (hit) begin
                    n_cmp_v   = 1'b0;
                    n_new_sym = e_sym;
                    n_new_err = 1'b0;
                    n_state   = hbd_pkg::ST_EMIT;
                end else if (r_addr < r_count) begin
                    ram_re  = 1'b1;
                    n_addr  = r_addr + 1'b1;
                    n_cmp_v = 1'b1;
                end else begin
                    n_cmp_v = 1'b0;
                    if (!r_cmp_v) begin
                        n_state = (r_left == 4'd0) ? hbd_pkg::ST_FLUSH : hbd_pkg::ST_SHIFT;
                    end
                end
            end
            hbd_pkg::ST_EMIT: begin
                // Release the held result and keep the new one
                if (!(r_pend_v && i_out_full)) begin
                    o_out_push = r_pend_v;
                    n_pend_v   = 1'b1;
                    n_pend_sym = r_new_sym;
                    n_pend_err = r_new_err;
                    n_buf      = '0;
                    n_held     = '0;
                    n_state    = (r_left == 4'd0) ? hbd_pkg::ST_FLUSH : hbd_pkg::ST_SHIFT;
                end
            end
            hbd_pkg::ST_FLUSH: begin
                // Drain the held result marked as last of its byte
                o_out_data = {r_pend_sym, r_pend_err, 1'b1};
                if (!r_pend_v) begin
                    n_state = hbd_pkg::ST_IDLE;
                end else if (!i_out_full) begin
                    o_out_push = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = hbd_pkg::ST_IDLE;
                end
            end
            default: n_state = hbd_pkg::ST_IDLE;
        endcase
    end
endmodule

### hdl/huffman_bitstream_decoder_core.sv
// Top level of the prefix-code bitstream decoder: front queue, engine, result queue.
// Depends on hbd_pkg, hbd_front, hbd_back and hbd_fifo.
//
// Table commands and stream starts are handled in the idle state. A decode word
// is dispatched from idle, takes one shift step for each used bit and ends in a
// closing step that releases its last result; a bit whose length matches some
// loaded code adds a search of the table memory at one entry per cycle, and each
// result adds an emit step, which waits while a result is held and the result
// queue is full. The table search through the single read port sets the worst
// case. Input and result queues let the input side and the result side stall
// independently.
module huffman_bitstream_decoder_core #(
    parameter int TABLE_DEPTH  = hbd_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_CODE_LEN = hbd_pkg::DEF_MAX_CODE_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [5:0]  i_code_length,
    input  logic [31:0] i_code_bits,
    input  logic [7:0]  i_symbol_in,
    input  logic [7:0]  i_data_byte,
    input  logic [3:0]  i_valid_bits,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_symbol,
    output logic        o_error,
    output logic        o_last
);
    hbd_pkg::t_item item;
    logic           item_avail, item_pop;
    logic           res_push, res_full;
    logic [hbd_pkg::RESULT_BITS-1:0] res_in, res_out;

    hbd_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_code_length (i_code_length),
        .i_code_bits   (i_code_bits),
        .i_symbol_in   (i_symbol_in),
        .i_data_byte   (i_data_byte),
        .i_valid_bits  (i_valid_bits),
        .i_pop         (item_pop),
        .o_avail       (item_avail),
        .o_item        (item)
    );

    hbd_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_avail    (item_avail),
        .i_item     (item),
        .o_pop      (item_pop),
        .i_out_full (res_full),
        .o_out_push (res_push),
        .o_out_data (res_in)
    );

    hbd_fifo #(
        .WIDTH (hbd_pkg::RESULT_BITS),
        .DEPTH (hbd_pkg::OUT_QUEUE_DEPTH)
    ) u_results (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_out)
    );

    assign {o_symbol, o_error, o_last} = res_out;
endmodule

### hdl/hbd_checker.sv
// Port-level checks of the decoder top level, bound to it.
// Depends only on the top level's ports.
module hbd_props (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [7:0] o_symbol,
    input logic       o_error,
    input logic       o_last
);
    // Reset leaves the result queue empty and the input queue not full
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // An error result carries no symbol
    a_err_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error) |-> (o_symbol == 8'd0))
        else $error("error result with nonzero symbol");

    // Flags of a waiting result are known
    a_err_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_error == 1'b0 || o_error == 1'b1) && (o_last == 1'b0 || o_last == 1'b1))
        else $error("result flags unknown");

    // A waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_symbol) && $stable(o_error) && $stable(o_last))
        else $error("waiting result changed");
endmodule

bind huffman_bitstream_decoder_core hbd_props u_hbd_props (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_symbol (o_symbol),
    .o_error  (o_error),
    .o_last   (o_last)
);
